// File: rtl/core/dpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DSI packet framer package
// Shared codes, constants and the job word passed from the front end to the
// back end of the framer.
// ----------------------------------------------------------------------------
package dpf_pkg;

   // Operation codes on the request channel.
   localparam logic [1:0] OP_SHORT   = 2'd0;
   localparam logic [1:0] OP_LONG    = 2'd1;
   localparam logic [1:0] OP_PAYLOAD = 2'd2;

   // Status codes carried on every response word.
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_STRAY  = 2'd1;
   localparam logic [1:0] STATUS_REOPEN = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_PAD_COUNT  = 1'b0;
   localparam logic CSR_CRC_ENABLE = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [5:0] PAD_COUNT_RESET  = 6'd32;
   localparam logic       CRC_ENABLE_RESET = 1'b1;

   // Default padding limit.
   localparam int MAX_PAD_DEFAULT = 32;

   // Depth of the job queue between the front and back ends.
   localparam int QUEUE_DEPTH = 2;

   // Fixed bytes of the packet format.
   localparam logic [7:0]  START_BYTE   = 8'hB8;
   localparam logic [7:0]  TRAILER_ONES = 8'hFF;
   localparam logic [7:0]  TRAILER_ZERO = 8'h00;
   localparam logic [15:0] CRC_SEED     = 16'hFFFF;

   // Kind of work the back end has to do for one request word.
   typedef enum logic [1:0] {
      JOB_SHORT,
      JOB_LONG,
      JOB_PAYLOAD,
      JOB_STRAY
   } job_kind_type;

   // One job: everything the back end needs to serialize its bytes.
   typedef struct packed {
      job_kind_type kind;
      logic [1:0]   status;
      logic [7:0]   data_type;
      logic [15:0]  header_word;
      logic [5:0]   ecc;
      logic [7:0]   payload_byte;
      logic [15:0]  crc;
      logic         tail;
   } job_type;

   // Byte sequencer states of the back end.
   typedef enum logic [3:0] {
      ST_START,
      ST_DT,
      ST_LO,
      ST_HI,
      ST_ECC,
      ST_DATA,
      ST_CRC_LO,
      ST_CRC_HI,
      ST_TRAILER,
      ST_PAD,
      ST_STRAY
   } back_state_type;

endpackage

// File: rtl/core/dpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DSI packet framer front end
// Accepts request words, tracks the open long packet and its running CRC,
// computes the header ECC and turns each word into a job for the back end.
// ----------------------------------------------------------------------------
module dpf_front import dpf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_data_type,
   input  logic [15:0] req_header_word,
   input  logic [7:0]  req_payload_byte,
   output logic        push,
   output job_type     job
);

   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [23:0] ECC_MASKS [6] = '{
      24'hF12CB7, 24'hF2555B, 24'h749A6D, 24'hB8E38E, 24'hDF03F0, 24'hEFFC00
   };

   // Reflected CRC-16 over one byte, one bit per step.
   function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc_in ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [15:0] crc_ff, crc_in;
   logic [23:0] ecc_word;
   logic [5:0]  ecc;
   logic [1:0]  hdr_status;

   // Header ECC: each bit is the parity of the header under one mask.
   assign ecc_word = {req_header_word, req_data_type};
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         ecc[i] = ^(ecc_word & ECC_MASKS[i]);
      end
   end

   assign hdr_status = (bytes_left_ff != 16'd0) ? STATUS_REOPEN : STATUS_OK;

   // Classify the word, build its job and update the packet state.
   always_comb begin
      bytes_left_in    = bytes_left_ff;
      crc_in           = crc_ff;
      push             = 1'b0;
      job.kind         = JOB_STRAY;
      job.status       = STATUS_OK;
      job.data_type    = req_data_type;
      job.header_word  = req_header_word;
      job.ecc          = ecc;
      job.payload_byte = req_payload_byte;
      job.crc          = crc_ff;
      job.tail         = 1'b0;
      if (accept) begin
         case (req_operation)
            OP_SHORT: begin
               push          = 1'b1;
               job.kind      = JOB_SHORT;
               job.status    = hdr_status;
               bytes_left_in = 16'd0;
            end
            OP_LONG: begin
               push          = 1'b1;
               job.kind      = JOB_LONG;
               job.status    = hdr_status;
               job.crc       = CRC_SEED;
               job.tail      = (req_header_word == 16'd0);
               crc_in        = CRC_SEED;
               bytes_left_in = req_header_word;
            end
            OP_PAYLOAD: begin
               push = 1'b1;
               if (bytes_left_ff == 16'd0) begin
                  job.kind   = JOB_STRAY;
                  job.status = STATUS_STRAY;
               end else begin
                  crc_in        = crc_update(crc_ff, req_payload_byte);
                  bytes_left_in = bytes_left_ff - 16'd1;
                  job.kind      = JOB_PAYLOAD;
                  job.crc       = crc_in;
                  job.tail      = (bytes_left_ff == 16'd1);
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   // Packet state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 16'd0;
         crc_ff        <= CRC_SEED;
      end else begin
         bytes_left_ff <= bytes_left_in;
         crc_ff        <= crc_in;
      end
   end

endmodule

// File: rtl/core/dpf_job_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DSI packet framer job queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module dpf_job_queue import dpf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output job_type head_job
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CntW-1:0] DepthCount = CntW'(QUEUE_DEPTH);
   localparam logic [PtrW-1:0] LastPtr    = PtrW'(QUEUE_DEPTH - 1);

   job_type         entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full      = (count_ff == DepthCount);
   assign not_empty = (count_ff != '0);
   assign head_job  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/core/dpf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DSI packet framer back end
// Byte sequencer that serializes one job at a time into the response
// register, one byte per unstalled cycle, with CRC tail, trailer and padding.
// ----------------------------------------------------------------------------
module dpf_back import dpf_pkg::*; #(
   parameter int MAX_PAD = MAX_PAD_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [5:0] pad_count,
   input  logic       crc_enable,
   input  logic       job_valid,
   input  job_type    head_job,
   output logic       job_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic [1:0] rsp_status
);

   localparam int PadW = $clog2(MAX_PAD + 2);
   localparam logic [PadW-1:0] PadOne = PadW'(1);

   back_state_type  state_ff, state_in;
   logic            active_ff, active_in;
   job_type         job_ff;
   logic [PadW-1:0] pad_cnt_ff, pad_cnt_in;
   logic [PadW-1:0] pads;
   logic            out_free, emit, last;
   logic [7:0]      byte_val;
   logic [7:0]      trailer;
   logic            take;
   logic            rsp_valid_ff;
   logic [7:0]      out_byte_ff;
   logic            run_last_ff;
   logic [1:0]      status_ff;

   // Padding length, saturated to the limit.
   always_comb begin
      if ({1'b0, pad_count} > 7'(MAX_PAD)) begin
         pads = PadW'(MAX_PAD);
      end else begin
         pads = PadW'(pad_count);
      end
   end

   // With CRC on, a long packet tail whose CRC top bit is set ends in a zero trailer.
   assign trailer = (job_ff.kind != JOB_SHORT && crc_enable && job_ff.crc[15])
                    ? TRAILER_ZERO : TRAILER_ONES;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = active_ff && out_free;
   assign take     = job_valid && (!active_ff || (emit && last));
   assign job_pop  = take;

   // Byte selection and next state.
   always_comb begin
      byte_val   = 8'h00;
      last       = 1'b0;
      state_in   = state_ff;
      pad_cnt_in = pad_cnt_ff;
      case (state_ff)
         ST_START: begin
            byte_val = START_BYTE;
            state_in = ST_DT;
         end
         ST_DT: begin
            byte_val = job_ff.data_type;
            state_in = ST_LO;
         end
         ST_LO: begin
            byte_val = job_ff.header_word[7:0];
            state_in = ST_HI;
         end
         ST_HI: begin
            byte_val = job_ff.header_word[15:8];
            state_in = ST_ECC;
         end
         ST_ECC: begin
            byte_val = {2'b00, job_ff.ecc};
            if (job_ff.kind == JOB_SHORT) begin
               state_in = ST_TRAILER;
            end else if (job_ff.tail) begin
               state_in = ST_CRC_LO;
            end else begin
               last = 1'b1;
            end
         end
         ST_DATA: begin
            byte_val = job_ff.payload_byte;
            if (job_ff.tail) begin
               state_in = ST_CRC_LO;
            end else begin
               last = 1'b1;
            end
         end
         ST_CRC_LO: begin
            byte_val = crc_enable ? job_ff.crc[7:0] : 8'h00;
            state_in = ST_CRC_HI;
         end
         ST_CRC_HI: begin
            byte_val = crc_enable ? job_ff.crc[15:8] : 8'h00;
            state_in = ST_TRAILER;
         end
         ST_TRAILER: begin
            byte_val   = trailer;
            pad_cnt_in = pads;
            if (pads == '0) begin
               last = 1'b1;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            byte_val   = trailer;
            pad_cnt_in = pad_cnt_ff - PadOne;
            last       = (pad_cnt_ff == PadOne);
         end
         ST_STRAY: begin
            byte_val = 8'h00;
            last     = 1'b1;
         end
         default: begin
            byte_val = 8'h00;
            last     = 1'b1;
         end
      endcase

      active_in = active_ff;
      if (emit && last) begin
         active_in = 1'b0;
      end
      if (take) begin
         active_in = 1'b1;
         case (head_job.kind)
            JOB_SHORT:   state_in = ST_START;
            JOB_LONG:    state_in = ST_START;
            JOB_PAYLOAD: state_in = ST_DATA;
            JOB_STRAY:   state_in = ST_STRAY;
            default:     state_in = ST_STRAY;
         endcase
      end else if (!emit) begin
         state_in   = state_ff;
         pad_cnt_in = pad_cnt_ff;
      end
   end

   // Sequencer control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_STRAY;
         active_ff  <= 1'b0;
         pad_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         active_ff  <= active_in;
         pad_cnt_ff <= pad_cnt_in;
      end
   end

   // Current job.
   always_ff @(posedge clock) begin
      if (take) begin
         job_ff <= head_job;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff <= byte_val;
         run_last_ff <= last;
         status_ff   <= job_ff.status;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = run_last_ff;
   assign rsp_status   = status_ff;

endmodule

// File: rtl/core/dsi_packet_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DSI packet framer
// Builds DSI short and long packets with header ECC, payload CRC-16, trailer
// and padding, as a stream of bytes on the response channel.
// ----------------------------------------------------------------------------
// The framer takes one request word per cycle as long as its two-entry job
// queue has room, and sends one response word (one byte of the stream) per
// cycle unless rsp_stall holds it. A short packet gives 6 + pad bytes, a long
// header 5 bytes (8 + pad when the word count is zero), a payload byte 1 byte
// (4 + pad when it is the last one), a stray payload byte 1 byte; pad is
// pad_count limited to MAX_PAD. The byte sequencer in the back end sets the
// rate: request words that each give one byte stream through at one per cycle
// unless rsp_stall holds them; a header stalls requests once the queue is full.
// Operation 3 is accepted with no response. The user must write configuration
// only while the framer is idle (not enforced); the csr port never stalls.
module dsi_packet_framer import dpf_pkg::*; #(
   parameter int MAX_PAD = MAX_PAD_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_data_type,
   input  logic [15:0] req_header_word,
   input  logic [7:0]  req_payload_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic [1:0]  rsp_status
);

   logic [5:0] pad_count_ff;
   logic       crc_enable_ff;
   logic       q_full, q_not_empty, q_pop;
   logic       front_push;
   job_type    front_job, head_job;
   logic       accept;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_count_ff  <= PAD_COUNT_RESET;
         crc_enable_ff <= CRC_ENABLE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PAD_COUNT:  pad_count_ff  <= csr_wdata;
            CSR_CRC_ENABLE: crc_enable_ff <= csr_wdata[0];
            default:        pad_count_ff  <= pad_count_ff;
         endcase
      end
   end

   // A word is taken whenever the job queue has room.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   dpf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_operation    (req_operation),
      .req_data_type    (req_data_type),
      .req_header_word  (req_header_word),
      .req_payload_byte (req_payload_byte),
      .push             (front_push),
      .job              (front_job)
   );

   dpf_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_job  (front_job),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   dpf_back #(
      .MAX_PAD (MAX_PAD)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pad_count    (pad_count_ff),
      .crc_enable   (crc_enable_ff),
      .job_valid    (q_not_empty),
      .head_job     (head_job),
      .job_pop      (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last),
      .rsp_status   (rsp_status)
   );

endmodule

// File: verif/tb_dsi_packet_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DSI packet framer testbench
// Feeds short packets, long headers, payload words, stray payload words and
// unused operations to the framer, under several padding and CRC settings.
// A behavioral packet builder predicts every byte of the stream, and a
// monitor checks each response word in order against it. Both channels
// stall and idle in random bursts.
// ----------------------------------------------------------------------------
module tb_dsi_packet_framer;
   import dpf_pkg::*;

   localparam int          PAD_LIMIT     = MAX_PAD_DEFAULT;
   localparam int          SETTLE_CYCLES = 16;
   localparam logic [1:0]  OP_UNUSED     = 2'd3;
   localparam logic [15:0] CRC_POLY_REV  = 16'h8408;

   // Header ECC parity masks, bit 0 in the lowest slot.
   localparam logic [5:0][23:0] ECC_MASKS = {
      24'hEFFC00, 24'hDF03F0, 24'hB8E38E, 24'h749A6D, 24'hF2555B, 24'hF12CB7
   };

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  data_type;
      logic [15:0] header_word;
      logic [7:0]  payload_byte;
   } dsi_request_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [1:0] status;
   } stream_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [5:0]  csr_wdata = 6'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = 2'd0;
   logic [7:0]  req_data_type = 8'd0;
   logic [15:0] req_header_word = 16'd0;
   logic [7:0]  req_payload_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic [1:0]  rsp_status;

   dsi_packet_framer #(.MAX_PAD(PAD_LIMIT)) dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_data_type(req_data_type),
      .req_header_word(req_header_word),
      .req_payload_byte(req_payload_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_last(rsp_run_last),
      .rsp_status(rsp_status)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Packet builder state and its copy of the configuration.
   logic [5:0]  cfg_pad     = PAD_COUNT_RESET;
   logic        cfg_crc_on  = CRC_ENABLE_RESET;
   logic [15:0] open_count  = 16'd0;
   logic [15:0] running_crc = CRC_SEED;

   dsi_request_type pending_requests[$];
   stream_byte_type expected_stream[$];

   dsi_request_type held_request;
   stream_byte_type seen_byte;
   stream_byte_type wanted_byte;
   bit              holding = 1'b0;
   bit              idle_on = 1'b1;
   int              gap_left = 0;
   int              stall_left = 0;
   int              error_count = 0;

   function automatic logic [5:0] header_ecc6(input logic [7:0] dt, input logic [15:0] hw);
      logic [23:0] hdr;
      logic [5:0]  ecc;
      hdr = {hw, dt};
      for (int i = 0; i < 6; i++) begin
         ecc[i] = ^(hdr & ECC_MASKS[i]);
      end
      return ecc;
   endfunction

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REV) : (c >> 1);
      end
      return c;
   endfunction

   task automatic push_byte(input logic [7:0] data, input logic [1:0] st);
      stream_byte_type w;
      w.data = data;
      w.last = 1'b0;
      w.status = st;
      expected_stream.push_back(w);
   endtask

   // Trailer followed by its padding copies, padding saturated at the limit.
   task automatic push_trailer_pad(input logic [7:0] trailer, input logic [1:0] st);
      int pads;
      pads = (cfg_pad > PAD_LIMIT) ? PAD_LIMIT : int'(cfg_pad);
      push_byte(trailer, st);
      repeat (pads) push_byte(trailer, st);
   endtask

   task automatic push_tail(input logic [1:0] st);
      if (cfg_crc_on) begin
         push_byte(running_crc[7:0], st);
         push_byte(running_crc[15:8], st);
         push_trailer_pad(running_crc[15] ? TRAILER_ZERO : TRAILER_ONES, st);
      end else begin
         push_byte(8'h00, st);
         push_byte(8'h00, st);
         push_trailer_pad(TRAILER_ONES, st);
      end
   endtask

   // Work out every byte that one accepted request word puts on the stream.
   task automatic frame_request(input dsi_request_type r);
      logic [1:0]      st;
      logic [5:0]      ecc;
      stream_byte_type w;
      if (r.operation != OP_UNUSED) begin
         if (r.operation == OP_PAYLOAD) begin
            if (open_count == 16'd0) begin
               push_byte(8'h00, STATUS_STRAY);
            end else begin
               push_byte(r.payload_byte, STATUS_OK);
               running_crc = crc16_byte(running_crc, r.payload_byte);
               open_count = open_count - 16'd1;
               if (open_count == 16'd0) push_tail(STATUS_OK);
            end
         end else begin
            // A new packet over an open payload drops that payload untailed.
            st = STATUS_OK;
            if (open_count != 16'd0) begin
               st = STATUS_REOPEN;
               open_count = 16'd0;
            end
            ecc = header_ecc6(r.data_type, r.header_word);
            push_byte(START_BYTE, st);
            push_byte(r.data_type, st);
            push_byte(r.header_word[7:0], st);
            push_byte(r.header_word[15:8], st);
            push_byte({2'b00, ecc}, st);
            if (r.operation == OP_SHORT) begin
               // A short packet carries no CRC, so its trailer is all ones.
               push_trailer_pad(TRAILER_ONES, st);
            end else begin
               running_crc = CRC_SEED;
               open_count = r.header_word;
               if (open_count == 16'd0) push_tail(st);
            end
         end
         w = expected_stream.pop_back();
         w.last = 1'b1;
         expected_stream.push_back(w);
      end
   endtask

   // Request driver: holds each word until accepted, idles in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            frame_request(held_request);
            holding = 1'b0;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
               gap_left = $urandom_range(0, 15);
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               held_request = pending_requests.pop_front();
               holding = 1'b1;
               req_valid <= 1'b1;
               req_operation <= held_request.operation;
               req_data_type <= held_request.data_type;
               req_header_word <= held_request.header_word;
               req_payload_byte <= held_request.payload_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each accepted word, stalls in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_byte.data = rsp_out_byte;
            seen_byte.last = rsp_run_last;
            seen_byte.status = rsp_status;
            if (expected_stream.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t: unexpected word byte=%h last=%b status=%0d", $realtime,
                     seen_byte.data, seen_byte.last, seen_byte.status);
               end
            end else begin
               wanted_byte = expected_stream.pop_front();
               if (seen_byte.data !== wanted_byte.data || seen_byte.last !== wanted_byte.last ||
                   seen_byte.status !== wanted_byte.status) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("%0t: mismatch byte=%h/%h last=%b/%b status=%0d/%0d (exp/act)",
                        $realtime, wanted_byte.data, seen_byte.data, wanted_byte.last,
                        seen_byte.last, wanted_byte.status, seen_byte.status);
                  end
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 15);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic queue_item(input logic [1:0] op, input logic [7:0] dt,
                             input logic [15:0] hw, input logic [7:0] pb);
      dsi_request_type r;
      r.operation = op;
      r.data_type = dt;
      r.header_word = hw;
      r.payload_byte = pb;
      pending_requests.push_back(r);
   endtask

   // Request word with random content in every field it does not set.
   task automatic queue_rand(input logic [1:0] op, input logic [15:0] hw);
      queue_item(op, 8'($urandom_range(0, 255)), hw, 8'($urandom_range(0, 255)));
   endtask

   task automatic queue_payload(input int count);
      repeat (count) queue_rand(OP_PAYLOAD, 16'($urandom_range(0, 65535)));
   endtask

   // Register writes happen only with the framer idle.
   task automatic write_register(input logic idx, input logic [5:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_PAD_COUNT) cfg_pad = value;
      else cfg_crc_on = value[0];
      csr_valid <= 1'b0;
   endtask

   // Wait until every word was accepted and every byte came back.
   task automatic wait_until_drained();
      do @(posedge clock);
      while (pending_requests.size() != 0 || holding || expected_stream.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly well-formed packets with random content, plus broken sequences
   // and noise. Every sequence leaves no payload open behind it.
   task automatic queue_random_traffic(input int target);
      int made;
      int pick;
      int count;
      int cut;
      made = 0;
      while (made < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            count = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            queue_rand(OP_LONG, 16'(count));
            queue_payload(count);
            made += 1 + count;
         end else if (pick < 70) begin
            queue_rand(OP_SHORT, 16'($urandom_range(0, 65535)));
            made += 1;
         end else if (pick < 80) begin
            // Huge word count cut short by a short packet.
            cut = $urandom_range(0, 4);
            queue_rand(OP_LONG, 16'($urandom_range(0, 65535)));
            queue_payload(cut);
            queue_rand(OP_SHORT, 16'($urandom_range(0, 65535)));
            made += 2 + cut;
         end else if (pick < 88) begin
            queue_rand(OP_PAYLOAD, 16'($urandom_range(0, 65535)));
            made += 1;
         end else if (pick < 95) begin
            queue_rand(OP_UNUSED, 16'($urandom_range(0, 65535)));
         end else begin
            // Truncated payload, then a complete long packet over it.
            count = $urandom_range(2, 12);
            cut = $urandom_range(1, count - 1);
            queue_rand(OP_LONG, 16'(count));
            queue_payload(cut);
            count = $urandom_range(0, 6);
            queue_rand(OP_LONG, 16'(count));
            queue_payload(count);
            made += 2 + cut + count;
         end
      end
   endtask

   // Run limit.
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Stimulus phases, each under its own register setting.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_register(CSR_PAD_COUNT, PAD_COUNT_RESET);
      write_register(CSR_CRC_ENABLE, {5'd0, CRC_ENABLE_RESET});

      // Directed: field extremes, every operation and the odd cases.
      queue_item(OP_SHORT, 8'h00, 16'h0000, 8'h00);
      queue_item(OP_SHORT, 8'hFF, 16'hFFFF, 8'hFF);
      queue_item(OP_SHORT, 8'h15, 16'h1234, 8'h5A);
      queue_item(OP_LONG, 8'h29, 16'h0000, 8'h00);
      queue_item(OP_LONG, 8'h39, 16'h0003, 8'h00);
      queue_item(OP_PAYLOAD, 8'h00, 16'h0000, 8'h00);
      queue_item(OP_PAYLOAD, 8'hFF, 16'hFFFF, 8'hFF);
      queue_item(OP_PAYLOAD, 8'h3C, 16'hA5C3, 8'hA5);
      queue_item(OP_PAYLOAD, 8'h00, 16'h0000, 8'h5A);
      queue_item(OP_UNUSED, 8'hFF, 16'hFFFF, 8'hFF);
      queue_item(OP_LONG, 8'h39, 16'hFFFF, 8'h00);
      queue_item(OP_PAYLOAD, 8'h00, 16'h0000, 8'h81);
      queue_item(OP_PAYLOAD, 8'h00, 16'h0000, 8'h7E);
      queue_item(OP_SHORT, 8'h05, 16'h00FF, 8'h00);
      queue_item(OP_LONG, 8'h29, 16'h0002, 8'h00);
      queue_item(OP_PAYLOAD, 8'h00, 16'h0000, 8'h11);
      queue_item(OP_LONG, 8'h39, 16'h0001, 8'h00);
      queue_item(OP_PAYLOAD, 8'h00, 16'h0000, 8'h22);
      queue_item(OP_LONG, 8'h29, 16'h0001, 8'h00);
      queue_item(OP_PAYLOAD, 8'h00, 16'h0000, 8'hFF);
      wait_until_drained();

      // No padding, CRC off; the write data sets every bit but the enable.
      write_register(CSR_PAD_COUNT, 6'd0);
      write_register(CSR_CRC_ENABLE, 6'h3E);
      queue_random_traffic(90);
      wait_until_drained();

      // Padding over the limit, CRC on, no idling for a stretch.
      idle_on = 1'b0;
      write_register(CSR_PAD_COUNT, 6'd63);
      write_register(CSR_CRC_ENABLE, 6'h01);
      queue_random_traffic(60);
      wait_until_drained();

      idle_on = 1'b1;
      write_register(CSR_PAD_COUNT, 6'd5);
      write_register(CSR_CRC_ENABLE, 6'h00);
      queue_random_traffic(80);
      wait_until_drained();

      write_register(CSR_PAD_COUNT, 6'($urandom_range(0, 63)));
      write_register(CSR_CRC_ENABLE, 6'h3F);
      queue_random_traffic(80);
      wait_until_drained();

      // Closing stretch without idling on either side.
      idle_on = 1'b0;
      write_register(CSR_PAD_COUNT, 6'd1);
      queue_random_traffic(70);
      wait_until_drained();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/dpf_pkg.sv
rtl/core/dpf_front.sv
rtl/core/dpf_job_queue.sv
rtl/core/dpf_back.sv
rtl/core/dsi_packet_framer.sv
verif/tb_dsi_packet_framer.sv
